/* design/bpu_pkg.sv */
// ----------------------------------------------------------------------------
// bpu_pkg
// Shared types and constants for the BMP pixel unpacker.
// ----------------------------------------------------------------------------
package bpu_pkg;

  // Default placement screen and size limit
  localparam int SCREEN_ROWS_DEF    = 480;
  localparam int SCREEN_COLUMNS_DEF = 800;
  localparam int MAX_DIMENSION_DEF  = 4096;

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int COLOR_W  = 32;
  localparam int COORD_W  = 14;
  localparam int DIM_W    = 13;
  localparam int COUNT_W  = 12;
  localparam int ORIGIN_W = 12;
  localparam int IDX_W    = 3;
  localparam int CFG_W    = 13;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_ALPHA_PRESENT = 3'd2,
    REG_TOP_DOWN      = 3'd3,
    REG_MIRRORED      = 3'd4,
    REG_ROW_ORIGIN    = 3'd5,
    REG_COLUMN_ORIGIN = 3'd6
  } cfg_reg_t;

  // Byte position within one pixel
  typedef enum logic [1:0] {
    PH_BLUE  = 2'd0,
    PH_GREEN = 2'd1,
    PH_RED   = 2'd2,
    PH_ALPHA = 2'd3
  } phase_t;

  // Settings as seen by the datapath, sizes already clamped
  typedef struct packed {
    logic [COUNT_W-1:0]  last_column;
    logic [COUNT_W-1:0]  last_row;
    logic [1:0]          pad_len;
    logic                alpha_present;
    logic                top_down;
    logic                mirrored;
    logic [ORIGIN_W-1:0] row_origin;
    logic [ORIGIN_W-1:0] column_origin;
  } cfg_t;

endpackage

/* design/bpu_byte_if.sv */
// ----------------------------------------------------------------------------
// bpu_byte_if
// Request channel carrying one raw pixel-array byte.
// ----------------------------------------------------------------------------
interface bpu_byte_if;
  logic                       valid;
  logic                       ready;
  logic [bpu_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

/* design/bpu_pixel_if.sv */
// ----------------------------------------------------------------------------
// bpu_pixel_if
// Request channel carrying one decoded pixel and its screen position.
// ----------------------------------------------------------------------------
interface bpu_pixel_if;
  logic                               valid;
  logic                               ready;
  logic [bpu_pkg::COLOR_W-1:0]        pixel_color;
  logic signed [bpu_pkg::COORD_W-1:0] screen_row;
  logic signed [bpu_pkg::COORD_W-1:0] screen_column;
  logic                               image_done;

  modport source (output valid, output pixel_color, output screen_row,
                  output screen_column, output image_done, input ready);
  modport sink   (input valid, input pixel_color, input screen_row,
                  input screen_column, input image_done, output ready);
endinterface

/* design/bpu_cfg_if.sv */
// ----------------------------------------------------------------------------
// bpu_cfg_if
// Register write channel: index and write data.
// ----------------------------------------------------------------------------
interface bpu_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [bpu_pkg::IDX_W-1:0] reg_index;
  logic [bpu_pkg::CFG_W-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

/* design/bpu_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bpu_cfg_regs
// Configuration registers and the clamped size terms derived from them.
// ----------------------------------------------------------------------------
module bpu_cfg_regs #(
  parameter int MAX_DIMENSION = bpu_pkg::MAX_DIMENSION_DEF
) (
  input  logic              clk,
  input  logic              rst,
  bpu_cfg_if.sink           cfg,
  output bpu_pkg::cfg_t     settings
);

  localparam logic [bpu_pkg::DIM_W-1:0] MAX_DIM = bpu_pkg::DIM_W'(MAX_DIMENSION);

  logic [bpu_pkg::DIM_W-1:0]    image_width;
  logic [bpu_pkg::DIM_W-1:0]    image_height;
  logic                         alpha_present;
  logic                         top_down;
  logic                         mirrored;
  logic [bpu_pkg::ORIGIN_W-1:0] row_origin;
  logic [bpu_pkg::ORIGIN_W-1:0] column_origin;

  logic [bpu_pkg::DIM_W-1:0]    width_eff;
  logic [bpu_pkg::DIM_W-1:0]    height_eff;
  logic [bpu_pkg::DIM_W-1:0]    width_m1;
  logic [bpu_pkg::DIM_W-1:0]    height_m1;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= bpu_pkg::DIM_W'(1);
      image_height  <= bpu_pkg::DIM_W'(1);
      alpha_present <= 1'b0;
      top_down      <= 1'b0;
      mirrored      <= 1'b0;
      row_origin    <= '0;
      column_origin <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        bpu_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg.wr_data;
        bpu_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg.wr_data;
        bpu_pkg::REG_ALPHA_PRESENT: alpha_present <= cfg.wr_data[0];
        bpu_pkg::REG_TOP_DOWN:      top_down      <= cfg.wr_data[0];
        bpu_pkg::REG_MIRRORED:      mirrored      <= cfg.wr_data[0];
        bpu_pkg::REG_ROW_ORIGIN:    row_origin    <= cfg.wr_data[bpu_pkg::ORIGIN_W-1:0];
        bpu_pkg::REG_COLUMN_ORIGIN: column_origin <= cfg.wr_data[bpu_pkg::ORIGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one, anything above the limit acts as the limit
  always_comb begin
    priority if (image_width == '0)     width_eff = bpu_pkg::DIM_W'(1);
    else if (image_width > MAX_DIM)     width_eff = MAX_DIM;
    else                                width_eff = image_width;

    priority if (image_height == '0)    height_eff = bpu_pkg::DIM_W'(1);
    else if (image_height > MAX_DIM)    height_eff = MAX_DIM;
    else                                height_eff = image_height;
  end

  assign width_m1  = width_eff - bpu_pkg::DIM_W'(1);
  assign height_m1 = height_eff - bpu_pkg::DIM_W'(1);

  // Row padding: 3*w bytes rounds up to a multiple of 4 after w mod 4 bytes
  assign settings.last_column   = width_m1[bpu_pkg::COUNT_W-1:0];
  assign settings.last_row      = height_m1[bpu_pkg::COUNT_W-1:0];
  assign settings.pad_len       = alpha_present ? 2'd0 : width_eff[1:0];
  assign settings.alpha_present = alpha_present;
  assign settings.top_down      = top_down;
  assign settings.mirrored      = mirrored;
  assign settings.row_origin    = row_origin;
  assign settings.column_origin = column_origin;

endmodule

/* design/bmp_pixel_unpacker.sv */
// ----------------------------------------------------------------------------
// bmp_pixel_unpacker
// Unpacks a 24/32-bit BMP pixel array byte stream into ARGB pixels with
// signed screen coordinates.
// ----------------------------------------------------------------------------
//
//   Channel       Dir   Carries                                        Ready
//   ------------  ----  ---------------------------------------------  ---------------
//   pixel_bytes   sink  data_byte                                      output free
//   pixels        src   pixel_color, screen_row/column, image_done     from consumer
//   cfg           sink  reg_index, wr_data                             always high
//
// One byte is taken per cycle; a pixel appears in the result register the
// cycle after its last byte (3 bytes at 24-bit depth, 4 with alpha).
// Byte-in ready drops only while the result register holds a pixel the
// consumer has not taken; ready follows pixels.ready combinationally, so a
// streaming consumer sees no bubbles. Row padding bytes and bytes after the
// final pixel are taken and dropped. Synchronous reset clears counters,
// byte phase and the result valid; registers go to their reset values.
// ----------------------------------------------------------------------------
module bmp_pixel_unpacker #(
  parameter int SCREEN_ROWS    = bpu_pkg::SCREEN_ROWS_DEF,
  parameter int SCREEN_COLUMNS = bpu_pkg::SCREEN_COLUMNS_DEF,
  parameter int MAX_DIMENSION  = bpu_pkg::MAX_DIMENSION_DEF
) (
  input  logic        clk,
  input  logic        rst,
  bpu_byte_if.sink    pixel_bytes,
  bpu_pixel_if.source pixels,
  bpu_cfg_if.sink     cfg
);

  localparam int CW = bpu_pkg::COORD_W;
  localparam logic [CW-1:0] ROW_BASE = CW'(SCREEN_ROWS - 1);
  localparam logic [CW-1:0] COL_BASE = CW'(SCREEN_COLUMNS - 1);

  bpu_pkg::cfg_t settings;

  // Stream state
  bpu_pkg::phase_t             phase;
  bpu_pkg::phase_t             phase_next;
  logic [23:0]                 partial_color;
  logic [23:0]                 partial_color_next;
  logic [bpu_pkg::COUNT_W-1:0] column_count;
  logic [bpu_pkg::COUNT_W-1:0] column_count_next;
  logic [bpu_pkg::COUNT_W-1:0] row_count;
  logic [bpu_pkg::COUNT_W-1:0] row_count_next;
  logic [1:0]                  pad_remaining;
  logic [1:0]                  pad_remaining_next;
  logic                        finished;
  logic                        finished_next;

  // Result register
  logic                        out_valid;
  logic [bpu_pkg::COLOR_W-1:0] out_color;
  logic [CW-1:0]               out_row;
  logic [CW-1:0]               out_column;
  logic                        out_done;

  logic                        byte_fire;
  logic                        emit;
  logic                        last_pixel;
  logic [bpu_pkg::COLOR_W-1:0] color;
  logic [CW-1:0]               row_sum;
  logic [CW-1:0]               col_sum;

  bpu_cfg_regs #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .settings (settings)
  );

  // Take a byte whenever the result register is free or being drained
  assign pixel_bytes.ready = !out_valid || pixels.ready;
  assign byte_fire         = pixel_bytes.valid && pixel_bytes.ready;

  // Screen position, wraps modulo 2^14
  always_comb begin
    if (settings.top_down) begin
      row_sum = CW'(row_count) + CW'(settings.row_origin);
    end else begin
      row_sum = ROW_BASE - CW'(row_count) - CW'(settings.row_origin);
    end
    if (settings.mirrored) begin
      col_sum = COL_BASE - CW'(column_count) - CW'(settings.column_origin);
    end else begin
      col_sum = CW'(column_count) + CW'(settings.column_origin);
    end
  end

  assign last_pixel = row_count >= settings.last_row;

  // Byte sequencing
  always_comb begin
    phase_next         = phase;
    partial_color_next = partial_color;
    column_count_next  = column_count;
    row_count_next     = row_count;
    pad_remaining_next = pad_remaining;
    finished_next      = finished;
    emit               = 1'b0;
    color              = {8'h00, pixel_bytes.data_byte, partial_color[15:0]};

    if (byte_fire && !finished) begin
      if (pad_remaining != 2'd0) begin
        pad_remaining_next = pad_remaining - 2'd1;
      end else begin
        unique case (phase)
          bpu_pkg::PH_BLUE: begin
            partial_color_next = {16'h0000, pixel_bytes.data_byte};
            phase_next         = bpu_pkg::PH_GREEN;
          end
          bpu_pkg::PH_GREEN: begin
            partial_color_next[15:8] = pixel_bytes.data_byte;
            phase_next               = bpu_pkg::PH_RED;
          end
          bpu_pkg::PH_RED: begin
            partial_color_next[23:16] = pixel_bytes.data_byte;
            if (settings.alpha_present) begin
              phase_next = bpu_pkg::PH_ALPHA;
            end else begin
              emit = 1'b1;
            end
          end
          bpu_pkg::PH_ALPHA: begin
            // taken as alpha even if alpha_present was cleared meanwhile
            color = {pixel_bytes.data_byte, partial_color};
            emit  = 1'b1;
          end
          default: ;
        endcase

        if (emit) begin
          phase_next = bpu_pkg::PH_BLUE;
          if (column_count >= settings.last_column) begin
            if (last_pixel) begin
              finished_next = 1'b1;
            end else begin
              column_count_next  = '0;
              row_count_next     = row_count + bpu_pkg::COUNT_W'(1);
              pad_remaining_next = settings.pad_len;
            end
          end else begin
            column_count_next = column_count + bpu_pkg::COUNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= bpu_pkg::PH_BLUE;
      partial_color <= '0;
      column_count  <= '0;
      row_count     <= '0;
      pad_remaining <= '0;
      finished      <= 1'b0;
    end else begin
      phase         <= phase_next;
      partial_color <= partial_color_next;
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      pad_remaining <= pad_remaining_next;
      finished      <= finished_next;
    end
  end

  // Result register: loads on emit, clears when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pixels.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_color  <= color;
      out_row    <= row_sum;
      out_column <= col_sum;
      out_done   <= finished_next;
    end
  end

  assign pixels.valid         = out_valid;
  assign pixels.pixel_color   = out_color;
  assign pixels.screen_row    = out_row;
  assign pixels.screen_column = out_column;
  assign pixels.image_done    = out_done;

`ifndef SYNTHESIS
  // Padding is skipped only between pixels
  assert property (@(posedge clk) disable iff (rst)
    pad_remaining != 2'd0 |-> phase == bpu_pkg::PH_BLUE)
    else $error("padding pending in mid-pixel");

  // Once the image is done nothing is left half-gathered
  assert property (@(posedge clk) disable iff (rst)
    finished |-> (pad_remaining == 2'd0 && phase == bpu_pkg::PH_BLUE))
    else $error("state not clean after final pixel");

  // A pixel produced is presented the next cycle
  assert property (@(posedge clk) disable iff (rst)
    emit |=> pixels.valid)
    else $error("emitted pixel not presented");

  // The final-pixel flag only comes out with the finished state
  assert property (@(posedge clk) disable iff (rst)
    (pixels.valid && pixels.image_done) |-> finished)
    else $error("image_done without finished state");
`endif

endmodule

/* sim/bmp_pixel_unpacker_test.sv */
// ----------------------------------------------------------------------------
// bmp_pixel_unpacker_test
// Self-checking bench for the BMP pixel unpacker. Byte requests go in with
// random gaps, and the pixel consumer stalls at random. A scoreboard decodes
// every accepted byte the same way the block should, and checks each pixel
// against the oldest one it still owes. The predicted fields are color,
// screen row and column, and the done flag.
// ----------------------------------------------------------------------------
module bmp_pixel_unpacker_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 500000;
  localparam int DRAIN_CYCLES    = 4;   // pixel shows in the cycle after its last byte
  localparam int PHASES          = 9;
  localparam int BYTES_PER_PHASE = 135;

  // One decoded pixel as the consumer sees it
  typedef struct packed {
    logic [bpu_pkg::COLOR_W-1:0] color;
    logic [bpu_pkg::COORD_W-1:0] row;
    logic [bpu_pkg::COORD_W-1:0] column;
    logic                        done;
  } pixel_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the registers and decode state, plus the pixels
  // still owed by the block, oldest first.
  // --------------------------------------------------------------------------
  class pixel_scoreboard;
    logic [bpu_pkg::DIM_W-1:0]    width_cfg;
    logic [bpu_pkg::DIM_W-1:0]    height_cfg;
    logic                         alpha_cfg;
    logic                         top_down_cfg;
    logic                         mirrored_cfg;
    logic [bpu_pkg::ORIGIN_W-1:0] row_origin_cfg;
    logic [bpu_pkg::ORIGIN_W-1:0] column_origin_cfg;

    bpu_pkg::phase_t              phase;
    logic [23:0]                  partial;
    logic [bpu_pkg::COUNT_W-1:0]  column_count;
    logic [bpu_pkg::COUNT_W-1:0]  row_count;
    logic [1:0]                   pad_left;
    logic                         finished;

    pixel_t                       owed_pixels[$];
    int                           errors;

    function new();
      width_cfg         = bpu_pkg::DIM_W'(1);
      height_cfg        = bpu_pkg::DIM_W'(1);
      alpha_cfg         = 1'b0;
      top_down_cfg      = 1'b0;
      mirrored_cfg      = 1'b0;
      row_origin_cfg    = '0;
      column_origin_cfg = '0;
      phase             = bpu_pkg::PH_BLUE;
      partial           = '0;
      column_count      = '0;
      row_count         = '0;
      pad_left          = '0;
      finished          = 1'b0;
      errors            = 0;
    endfunction

    function void write_reg(bpu_pkg::cfg_reg_t idx, logic [bpu_pkg::CFG_W-1:0] value);
      case (idx)
        bpu_pkg::REG_IMAGE_WIDTH:   width_cfg         = value;
        bpu_pkg::REG_IMAGE_HEIGHT:  height_cfg        = value;
        bpu_pkg::REG_ALPHA_PRESENT: alpha_cfg         = value[0];
        bpu_pkg::REG_TOP_DOWN:      top_down_cfg      = value[0];
        bpu_pkg::REG_MIRRORED:      mirrored_cfg      = value[0];
        bpu_pkg::REG_ROW_ORIGIN:    row_origin_cfg    = value[bpu_pkg::ORIGIN_W-1:0];
        bpu_pkg::REG_COLUMN_ORIGIN: column_origin_cfg = value[bpu_pkg::ORIGIN_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the decoder by one accepted byte; queue a pixel if one completes
    function void decode_byte(logic [bpu_pkg::BYTE_W-1:0] b);
      pixel_t px;
      int     w;
      int     h;
      int     r;
      int     c;
      if (finished) return;
      if (pad_left != 2'd0) begin
        pad_left = pad_left - 2'd1;
        return;
      end
      case (phase)
        bpu_pkg::PH_BLUE: begin
          partial = {16'h0000, b};
          phase   = bpu_pkg::PH_GREEN;
          return;
        end
        bpu_pkg::PH_GREEN: begin
          partial[15:8] = b;
          phase         = bpu_pkg::PH_RED;
          return;
        end
        bpu_pkg::PH_RED: begin
          partial[23:16] = b;
          if (alpha_cfg) begin
            phase = bpu_pkg::PH_ALPHA;
            return;
          end
          px.color = {8'h00, partial};
        end
        // alpha byte is taken even if alpha was switched off meanwhile
        default: px.color = {b, partial};
      endcase
      phase = bpu_pkg::PH_BLUE;

      if (top_down_cfg) r = int'(row_count) + int'(row_origin_cfg);
      else r = bpu_pkg::SCREEN_ROWS_DEF - 1 - int'(row_count) - int'(row_origin_cfg);
      if (mirrored_cfg)
        c = bpu_pkg::SCREEN_COLUMNS_DEF - 1 - int'(column_count)
            - int'(column_origin_cfg);
      else c = int'(column_count) + int'(column_origin_cfg);
      px.row    = r[bpu_pkg::COORD_W-1:0];
      px.column = c[bpu_pkg::COORD_W-1:0];

      // zero acts as one, oversize acts as the limit
      if (width_cfg == 0) w = 1;
      else if (width_cfg > bpu_pkg::MAX_DIMENSION_DEF) w = bpu_pkg::MAX_DIMENSION_DEF;
      else w = int'(width_cfg);
      if (height_cfg == 0) h = 1;
      else if (height_cfg > bpu_pkg::MAX_DIMENSION_DEF) h = bpu_pkg::MAX_DIMENSION_DEF;
      else h = int'(height_cfg);
      px.done = 1'b0;
      if (int'(column_count) >= w - 1) begin
        if (int'(row_count) >= h - 1) begin
          finished = 1'b1;
          px.done  = 1'b1;
        end else begin
          column_count = '0;
          row_count    = row_count + bpu_pkg::COUNT_W'(1);
          pad_left     = 2'((4 - (w * (alpha_cfg ? 4 : 3)) % 4) % 4);
        end
      end else begin
        column_count = column_count + bpu_pkg::COUNT_W'(1);
      end
      owed_pixels.push_back(px);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] pixel mismatch: %s", $time, msg);
    endtask

    task check_pixel(logic [bpu_pkg::COLOR_W-1:0] color,
                     logic [bpu_pkg::COORD_W-1:0] row,
                     logic [bpu_pkg::COORD_W-1:0] column, logic done);
      pixel_t want;
      if (owed_pixels.size() == 0) begin
        report($sformatf("unexpected pixel color %h row %0d column %0d",
                         color, $signed(row), $signed(column)));
        return;
      end
      want = owed_pixels.pop_front();
      if (color !== want.color)
        report($sformatf("color %h, want %h", color, want.color));
      if (row !== want.row)
        report($sformatf("row %0d, want %0d", $signed(row), $signed(want.row)));
      if (column !== want.column)
        report($sformatf("column %0d, want %0d", $signed(column), $signed(want.column)));
      if (done !== want.done)
        report($sformatf("done %b, want %b", done, want.done));
    endtask
  endclass

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   cycle_count;

  pixel_scoreboard board;

  bpu_byte_if  byte_ch ();
  bpu_pixel_if pixel_ch ();
  bpu_cfg_if   cfg_ch ();

  bmp_pixel_unpacker uut (
    .clk         (clk),
    .rst         (rst),
    .pixel_bytes (byte_ch),
    .pixels      (pixel_ch),
    .cfg         (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Consumer side: ready re-rolled every cycle against the current stall rate
  initial begin
    pixel_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      pixel_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: results are checked before the byte of the same edge is decoded,
  // since a byte's pixel can only come out on a later edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_ch.valid && pixel_ch.ready)
        board.check_pixel(pixel_ch.pixel_color, pixel_ch.screen_row,
                          pixel_ch.screen_column, pixel_ch.image_done);
      if (byte_ch.valid && byte_ch.ready)
        board.decode_byte(byte_ch.data_byte);
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task set_idling(int sender, int receiver);
    send_idle_pct = sender;
    recv_idle_pct = receiver;
  endtask

  // One byte request; valid stays high afterwards unless the next call idles
  task send_byte(logic [bpu_pkg::BYTE_W-1:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
  endtask

  // Up to four bytes, lowest byte first
  task send_bytes(logic [31:0] data, int count);
    for (int i = 0; i < count; i++) send_byte(data[8*i +: 8]);
  endtask

  task write_reg(bpu_pkg::cfg_reg_t idx, logic [bpu_pkg::CFG_W-1:0] value);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data   <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    board.write_reg(idx, value);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task apply_settings(logic [bpu_pkg::CFG_W-1:0] w, logic [bpu_pkg::CFG_W-1:0] h,
                      logic alpha, logic top_down, logic mirrored,
                      logic [bpu_pkg::ORIGIN_W-1:0] row_org,
                      logic [bpu_pkg::ORIGIN_W-1:0] col_org);
    write_reg(bpu_pkg::REG_IMAGE_WIDTH, w);
    write_reg(bpu_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(bpu_pkg::REG_ALPHA_PRESENT, bpu_pkg::CFG_W'(alpha));
    write_reg(bpu_pkg::REG_TOP_DOWN, bpu_pkg::CFG_W'(top_down));
    write_reg(bpu_pkg::REG_MIRRORED, bpu_pkg::CFG_W'(mirrored));
    write_reg(bpu_pkg::REG_ROW_ORIGIN, bpu_pkg::CFG_W'(row_org));
    write_reg(bpu_pkg::REG_COLUMN_ORIGIN, bpu_pkg::CFG_W'(col_org));
  endtask

  // Stop sending and wait until every owed pixel is in. The first edge lets
  // the monitor see the last byte request; the tail covers padding bytes
  // still in flight, which owe nothing.
  task drain();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.owed_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [bpu_pkg::ORIGIN_W-1:0] pick_origin();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return bpu_pkg::ORIGIN_W'($urandom_range(4095));
    endcase
  endfunction

  function automatic logic [bpu_pkg::CFG_W-1:0] pick_width();
    case ($urandom_range(9))
      0:       return '0;                                  // acts as one
      1:       return '1;                                  // clamps to the limit
      2:       return bpu_pkg::CFG_W'(bpu_pkg::MAX_DIMENSION_DEF);
      3:       return bpu_pkg::CFG_W'($urandom_range(8190, bpu_pkg::MAX_DIMENSION_DEF + 1));
      4:       return bpu_pkg::CFG_W'($urandom_range(200, 13));
      default: return bpu_pkg::CFG_W'($urandom_range(12, 1));  // short rows, lots of padding
    endcase
  endfunction

  initial begin
    logic [bpu_pkg::CFG_W-1:0] last_height;
    board = new();
    rst   <= 1'b1;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.reg_index  <= bpu_pkg::REG_IMAGE_WIDTH;
    cfg_ch.wr_data    <= '0;
    set_idling(32, 80);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- Directed ----------------------------------------------------------
    // The reset size is one pixel, so a tall image goes in before any byte.
    // Width zero acts as one: each pixel is its own row with one pad byte.
    apply_settings('0, bpu_pkg::CFG_W'(bpu_pkg::MAX_DIMENSION_DEF), 1'b0, 1'b0, 1'b0,
                   '0, '0);
    send_bytes(32'h5A000000, 4);
    send_bytes(32'hA5FFFFFF, 4);
    send_bytes(32'hC37F8001, 4);
    drain();

    // Oversize width, alpha, top-down, mirrored, origins at their top
    apply_settings('1, bpu_pkg::CFG_W'(bpu_pkg::MAX_DIMENSION_DEF), 1'b1, 1'b1, 1'b1,
                   '1, '1);
    send_bytes(32'h78563412, 4);
    send_bytes(32'h00FF00FF, 4);
    // Alpha switched off with the alpha byte still to come: it is still alpha
    send_bytes(32'h00DEBC9A, 3);
    drain();
    write_reg(bpu_pkg::REG_ALPHA_PRESENT, '0);
    send_bytes(32'h000000F0, 1);
    drain();
    // Width cut below the current column: the next pixel closes the row
    write_reg(bpu_pkg::REG_IMAGE_WIDTH, bpu_pkg::CFG_W'(2));
    send_bytes(32'h00332211, 3);
    drain();

    // ---- Random ------------------------------------------------------------
    // Any byte stream is a legal pixel array, so every byte is random. Height
    // stays above the rows this run can reach so the image keeps going.
    for (int p = 0; p < PHASES; p++) begin
      if (p < PHASES / 3) set_idling(32, 80);
      else if (p < 2 * PHASES / 3) set_idling(80, 32);
      else set_idling(0, 0);
      apply_settings(pick_width(), bpu_pkg::CFG_W'($urandom_range(8191, 1000)),
                     1'($urandom_range(1)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), pick_origin(), pick_origin());
      repeat (BYTES_PER_PHASE) send_byte(bpu_pkg::BYTE_W'($urandom_range(255)));
      drain();
    end

    // ---- End of image --------------------------------------------------------
    // Height zero, one, or just enough for the current row: the image ends
    // when this row closes. Bytes after that must be swallowed.
    set_idling(0, 0);
    case ($urandom_range(2))
      0:       last_height = '0;
      1:       last_height = bpu_pkg::CFG_W'(1);
      default: last_height = bpu_pkg::CFG_W'(board.row_count) + bpu_pkg::CFG_W'(1);
    endcase
    apply_settings(bpu_pkg::CFG_W'($urandom_range(6, 1)), last_height,
                   1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                   pick_origin(), pick_origin());
    while (!board.finished) send_byte(bpu_pkg::BYTE_W'($urandom_range(255)));
    repeat (16) send_byte(bpu_pkg::BYTE_W'($urandom_range(255)));
    drain();

    if (board.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
